// ===== src/bmr_pkg.sv =====
package bmr_pkg;

  localparam int MaxSubjects = 256;
  localparam int IdxW        = $clog2(MaxSubjects);
  localparam int CntW        = IdxW + 1;
  localparam int ScoreW      = 32;
  localparam int RankW       = CntW + 1;
  localparam int SumW        = CntW + RankW - 2;
  localparam int SdW         = SumW + 1;
  localparam int SqW         = CntW + 2 * RankW - 3;
  localparam int ResW        = 32;

  // serial multiplier and divider widths
  localparam int MulAW   = 128;
  localparam int MulBW   = 48;
  localparam int MulCntW = $clog2(MulBW);
  localparam int DivNW   = 128;
  localparam int DivDW   = 96;
  localparam int DivCntW = $clog2(DivNW);

  localparam logic ActScore  = 1'b0;
  localparam logic ActMember = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StIssue,
    StKey,
    StSweep,
    StGWrite,
    StAcc,
    StCheck,
    StCalc,
    StDiv1,
    StSqrt,
    StDiv2,
    StOut
  } state_e;

endpackage

// ===== src/bmr_if.sv =====
interface bmr_req_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [bmr_pkg::IdxW-1:0]  subject_index;
  logic signed [31:0]        score;
  logic                      lesioned;
  modport source (output valid, action, subject_index, score, lesioned, input ready);
  modport sink   (input valid, action, subject_index, score, lesioned, output ready);
endinterface

interface bmr_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] statistic;
  logic [31:0]        degrees_freedom;
  logic               invalid;
  modport source (output valid, statistic, degrees_freedom, invalid, input ready);
  modport sink   (input valid, statistic, degrees_freedom, invalid, output ready);
endinterface

interface bmr_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] subject_count;
  modport source (output valid, subject_count, input ready);
  modport sink   (input valid, subject_count, output ready);
endinterface

// ===== src/bmr_mul.sv =====
module bmr_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bmr_pkg::MulAW-1:0] a_i,
  input  logic [bmr_pkg::MulBW-1:0] b_i,
  output logic                      done_o,
  output logic [bmr_pkg::MulAW-1:0] prod_o
);
  import bmr_pkg::*;

  logic [MulAW-1:0]   a_q, acc_q;
  logic [MulBW-1:0]   b_q;
  logic [MulCntW-1:0] cnt_q;
  logic               busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // one multiplier bit per cycle, shift and add
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
      cnt_q <= MulCntW'(MulBW - 1);
    end else if (busy_q) begin
      if (b_q[0]) acc_q <= acc_q + a_q;
      a_q   <= a_q << 1;
      b_q   <= b_q >> 1;
      cnt_q <= cnt_q - MulCntW'(1);
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== src/bmr_div.sv =====
module bmr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bmr_pkg::DivNW-1:0] num_i,
  input  logic [bmr_pkg::DivDW-1:0] den_i,
  output logic                      done_o,
  output logic [bmr_pkg::DivNW-1:0] quo_o
);
  import bmr_pkg::*;

  logic [DivNW-1:0]   quo_q;
  logic [DivDW-1:0]   rem_q, den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DivDW:0]     shifted;
  logic [DivDW+1:0]   diff;

  assign shifted = {rem_q, quo_q[DivNW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
      cnt_q <= DivCntW'(DivNW - 1);
    end else if (busy_q) begin
      if (!diff[DivDW+1]) begin
        rem_q <= diff[DivDW-1:0];
        quo_q <= {quo_q[DivNW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DivDW-1:0];
        quo_q <= {quo_q[DivNW-2:0], 1'b0};
      end
      cnt_q <= cnt_q - DivCntW'(1);
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== src/brunner_munzel_rank_test_core.sv =====
// Channel  Dir  Handshake    Payload
// req_i    in   valid/ready  action, subject_index, score, lesioned
// res_o    out  valid/ready  statistic, degrees_freedom, invalid
// cfg_i    in   valid/ready  subject_count (always ready)
//
// A membership request makes one sweep of the score memory (one read port, one
// entry a cycle) to count the global rank. The last subject of a column adds
// within-group sweeps and up to 20 serial multiplies, two divisions and a square
// root, cut short when a group has under two members or the variance sum is zero.
// rst_ni clears control only and there is no clearing pass: scores, ranks and
// lesion bits are to be written before they are read; the block does not enforce it.
// A finished result waits in the output register while new requests are taken.
module brunner_munzel_rank_test_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmr_req_if.sink   req_i,
  bmr_res_if.source res_o,
  bmr_cfg_if.sink   cfg_i
);
  import bmr_pkg::*;

  // micro-steps of the closing arithmetic
  localparam logic [4:0] StepCnt0 = 5'd0,  StepG0   = 5'd1,  StepCnt1 = 5'd2;
  localparam logic [4:0] StepG1   = 5'd3,  StepX    = 5'd4,  StepY    = 5'd5;
  localparam logic [4:0] StepK    = 5'd6,  StepT0   = 5'd7,  StepT    = 5'd8;
  localparam logic [4:0] StepNa   = 5'd9,  StepNb   = 5'd10, StepDa   = 5'd11;
  localparam logic [4:0] StepDen1 = 5'd12, StepMa   = 5'd13, StepMb   = 5'd14;
  localparam logic [4:0] StepMc   = 5'd15, StepEa   = 5'd16, StepEb   = 5'd17;
  localparam logic [4:0] StepEc   = 5'd18, StepDen2 = 5'd19;

  state_e state_q, state_d;

  // storage: scores in one RAM, lesion bit with doubled global midrank in another
  logic signed [ScoreW-1:0] score_mem [MaxSubjects];
  logic [RankW:0]           grank_mem [MaxSubjects];
  logic signed [ScoreW-1:0] score_rd_q;
  logic [RankW:0]           grank_rd_q;
  logic [IdxW-1:0]          rd_addr;

  logic [8:0]          sc_q;
  logic [CntW-1:0]     n_used;
  logic [IdxW-1:0]     cur_q;
  logic [CntW-1:0]     j_q, less_q, eq_q;
  logic                pv_q, final_q, grp_q, run_q, les_q;
  logic signed [ScoreW-1:0] key_q;
  logic [RankW-1:0]    r_q, rank_w, d_mag;
  logic signed [RankW:0] d_w;
  logic [2*RankW-1:0]  d_sq;
  logic                last_w, issue_w, req_acc;

  logic [SumW-1:0]     s_q [2];
  logic signed [SdW-1:0] sd_q [2];
  logic signed [SdW-1:0] sd_sel;
  logic [SdW-1:0]      sd_mag;
  logic [SqW-1:0]      sq_q [2];
  logic [CntW-1:0]     cnt_q [2];
  logic [7:0]          p_w, r_w;

  logic [4:0]          step_q;
  logic [MulAW-1:0]    tmp_q, num_q, den_q;
  logic [35:0]         g0_q, g1_q;
  logic [47:0]         x_q, y_q, w_q, wsum;
  logic [15:0]         k_q;
  logic signed [27:0]  t_q;
  logic [27:0]         abs_t;

  logic                mul_start, mul_done, div_start, div_done;
  logic [MulAW-1:0]    mul_a, prod;
  logic [MulBW-1:0]    mul_b;
  logic [DivNW-1:0]    div_num, quo;
  logic [DivDW-1:0]    div_den;

  logic [63:0]         sv_q, sres_q, sbit_q, ssum;
  logic                inv_q, out_load, out_valid_q, out_inv_q;
  logic [ResW-1:0]     stat_q, df_q, out_stat_q, out_df_q;

  // clamp the subject count to [2, MaxSubjects]
  always_comb begin
    if (sc_q < 9'd2) n_used = CntW'(2);
    else if ({1'b0, sc_q} > 10'(MaxSubjects)) n_used = CntW'(MaxSubjects);
    else n_used = CntW'(sc_q);
  end

  assign last_w  = ({1'b0, cur_q} == n_used - CntW'(1));
  assign issue_w = (j_q < n_used);
  assign req_acc = req_i.valid && req_i.ready;
  assign rank_w  = RankW'({less_q, 1'b0}) + RankW'(eq_q) + RankW'(1);
  // a score reloaded after its rank was kept can make the difference negative
  assign d_w     = $signed({1'b0, r_q}) - $signed({1'b0, rank_w});
  assign d_mag   = d_w[RankW] ? RankW'(-d_w) : d_w[RankW-1:0];
  assign d_sq    = d_mag * d_mag;
  assign sd_sel  = (step_q == StepG1) ? sd_q[1] : sd_q[0];
  assign sd_mag  = sd_sel[SdW-1] ? $unsigned(-sd_sel) : $unsigned(sd_sel);
  assign p_w     = 8'(cnt_q[0] - CntW'(1));
  assign r_w     = 8'(cnt_q[1] - CntW'(1));
  assign wsum    = x_q + y_q;
  assign abs_t   = t_q[27] ? 28'(-t_q) : 28'(t_q);
  assign ssum    = sres_q + sbit_q;

  assign req_i.ready = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;

  // next state and strobes
  always_comb begin
    state_d   = state_q;
    rd_addr   = cur_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (req_acc && req_i.action == ActMember &&
            {1'b0, req_i.subject_index} < n_used) state_d = StIssue;
      end
      StIssue: state_d = StKey;
      StKey:   state_d = StSweep;
      StSweep: begin
        rd_addr = j_q[IdxW-1:0];
        if (!issue_w && !pv_q) state_d = final_q ? StAcc : StGWrite;
      end
      StGWrite: state_d = last_w ? StIssue : StIdle;
      StAcc:    state_d = last_w ? StCheck : StIssue;
      StCheck: begin
        if (cnt_q[0] < CntW'(2) || cnt_q[1] < CntW'(2)) state_d = StOut;
        else state_d = StCalc;
      end
      StCalc: begin
        if (!run_q) mul_start = 1'b1;
        else if (mul_done) begin
          if (step_q == StepK && wsum == '0) state_d = StOut;
          else if (step_q == StepDen1) state_d = StDiv1;
          else if (step_q == StepDen2) state_d = StDiv2;
        end
      end
      StDiv1: begin
        if (!run_q) div_start = 1'b1;
        else if (div_done) state_d = (quo[DivNW-1:62] != '0) ? StCalc : StSqrt;
      end
      StSqrt: if (sbit_q == '0) state_d = StCalc;
      StDiv2: begin
        if (!run_q) div_start = 1'b1;
        else if (div_done) state_d = StOut;
      end
      StOut: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q        <= 9'd256;
      pv_q        <= 1'b0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) sc_q <= cfg_i.subject_count;
      pv_q <= (state_q == StSweep) && issue_w;
      if (mul_start || div_start) run_q <= 1'b1;
      else if (mul_done || div_done) run_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (req_acc && req_i.action == ActScore)
      score_mem[req_i.subject_index] <= req_i.score;
    if (state_q == StGWrite) grank_mem[cur_q] <= {les_q, rank_w};
    score_rd_q <= score_mem[rd_addr];
    grank_rd_q <= grank_mem[rd_addr];
  end

  // rank sweeps and group sums
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        cur_q   <= req_i.subject_index;
        les_q   <= req_i.lesioned;
        final_q <= 1'b0;
      end
      StKey: begin
        key_q  <= score_rd_q;
        r_q    <= grank_rd_q[RankW-1:0];
        grp_q  <= grank_rd_q[RankW];
        j_q    <= '0;
        less_q <= '0;
        eq_q   <= '0;
      end
      StSweep: begin
        if (issue_w) j_q <= j_q + CntW'(1);
        // drop subjects of the other group in the within-group pass
        if (pv_q && (!final_q || grank_rd_q[RankW] == grp_q)) begin
          if (score_rd_q < key_q) less_q <= less_q + CntW'(1);
          else if (score_rd_q == key_q) eq_q <= eq_q + CntW'(1);
        end
      end
      StGWrite: begin
        if (last_w) begin
          cur_q   <= '0;
          final_q <= 1'b1;
          for (int g = 0; g < 2; g++) begin
            s_q[g]   <= '0;
            sd_q[g]  <= '0;
            sq_q[g]  <= '0;
            cnt_q[g] <= '0;
          end
        end
      end
      StAcc: begin
        s_q[grp_q]   <= s_q[grp_q] + SumW'(r_q);
        sd_q[grp_q]  <= sd_q[grp_q] + SdW'(d_w);
        sq_q[grp_q]  <= sq_q[grp_q] + SqW'(d_sq);
        cnt_q[grp_q] <= cnt_q[grp_q] + CntW'(1);
        cur_q        <= cur_q + IdxW'(1);
      end
      default: ;
    endcase
  end

  // serial multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      StepCnt0: begin mul_a = MulAW'(cnt_q[0]); mul_b = MulBW'(sq_q[0]); end
      StepG0:   begin mul_a = MulAW'(sd_mag);   mul_b = MulBW'(sd_mag); end
      StepCnt1: begin mul_a = MulAW'(cnt_q[1]); mul_b = MulBW'(sq_q[1]); end
      StepG1:   begin mul_a = MulAW'(sd_mag);   mul_b = MulBW'(sd_mag); end
      StepX:    begin mul_a = MulAW'(g0_q);     mul_b = MulBW'(r_w); end
      StepY:    begin mul_a = MulAW'(g1_q);     mul_b = MulBW'(p_w); end
      StepK:    begin mul_a = MulAW'(p_w);      mul_b = MulBW'(r_w); end
      StepT0:   begin mul_a = MulAW'(s_q[0]);   mul_b = MulBW'(cnt_q[1]); end
      StepT:    begin mul_a = MulAW'(s_q[1]);   mul_b = MulBW'(cnt_q[0]); end
      StepNa:   begin mul_a = MulAW'(abs_t);    mul_b = MulBW'(abs_t); end
      StepNb:   begin mul_a = num_q;            mul_b = MulBW'(k_q); end
      StepDa:   begin mul_a = MulAW'(w_q);      mul_b = MulBW'(n_used); end
      StepDen1: begin mul_a = den_q;            mul_b = MulBW'(n_used); end
      StepMa:   begin mul_a = MulAW'(w_q);      mul_b = w_q; end
      StepMb:   begin mul_a = num_q;            mul_b = MulBW'(p_w); end
      StepMc:   begin mul_a = num_q;            mul_b = MulBW'(r_w); end
      StepEa:   begin mul_a = MulAW'(x_q);      mul_b = x_q; end
      StepEb:   begin mul_a = den_q;            mul_b = MulBW'(r_w); end
      StepEc:   begin mul_a = MulAW'(y_q);      mul_b = y_q; end
      StepDen2: begin mul_a = tmp_q;            mul_b = MulBW'(p_w); end
      default: ;
    endcase
  end

  assign div_num = (state_q == StDiv1) ? (num_q << 32) : (num_q << 16);
  assign div_den = den_q[DivDW-1:0];

  // closing arithmetic
  always_ff @(posedge clk_i) begin
    if (state_q == StCheck) begin
      step_q <= StepCnt0;
      inv_q  <= (cnt_q[0] < CntW'(2) || cnt_q[1] < CntW'(2));
    end
    if (state_q == StCalc && mul_done) begin
      step_q <= step_q + 5'd1;
      case (step_q)
        StepCnt0, StepCnt1, StepT0, StepEc: tmp_q <= prod;
        StepG0: g0_q <= tmp_q[35:0] - prod[35:0];
        StepG1: g1_q <= tmp_q[35:0] - prod[35:0];
        StepX:  x_q <= prod[47:0];
        StepY:  y_q <= prod[47:0];
        StepK: begin
          k_q <= prod[15:0];
          w_q <= wsum;
          if (wsum == '0) inv_q <= 1'b1;
        end
        StepT: t_q <= $signed(tmp_q[27:0] - prod[27:0]);
        StepNa, StepNb, StepMa, StepMb, StepMc: num_q <= prod;
        StepDa, StepDen1, StepEa, StepEb: den_q <= prod;
        StepDen2: den_q <= den_q + prod;
        default: ;
      endcase
    end
    if (state_q == StDiv1 && div_done) begin
      // saturate when the squared ratio reaches 2^62
      stat_q <= t_q[27] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sv_q   <= quo[63:0];
      sres_q <= '0;
      sbit_q <= 64'h4000_0000_0000_0000;
    end
    if (state_q == StSqrt) begin
      if (sbit_q != '0) begin
        if (sv_q >= ssum) begin
          sv_q   <= sv_q - ssum;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end else begin
        stat_q <= t_q[27] ? 32'(-sres_q[31:0]) : sres_q[31:0];
      end
    end
    if (state_q == StDiv2 && div_done)
      df_q <= (quo[DivNW-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
    if (out_load) begin
      out_inv_q  <= inv_q;
      out_stat_q <= inv_q ? '0 : stat_q;
      out_df_q   <= inv_q ? '0 : df_q;
    end
  end

  bmr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  bmr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign res_o.valid           = out_valid_q;
  assign res_o.statistic       = out_stat_q;
  assign res_o.degrees_freedom = out_df_q;
  assign res_o.invalid         = out_inv_q;

  // the shared units only finish inside their own phases
  a_mul_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == StCalc) else $error("multiply finished outside calc");
  a_div_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv1 || state_q == StDiv2))
    else $error("divide finished outside divide phase");
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (state_q == StSweep && j_q <= n_used)) else $error("sweep overran");
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_inv_q) |-> (out_stat_q == '0 && out_df_q == '0))
    else $error("invalid result carries values");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || res_o.ready)) else $error("result overwritten");

endmodule

// ===== verif/tb.sv =====
module tb;
  import bmr_pkg::*;

  localparam int WatchdogLimit = 200000;
  localparam int SettleCycles  = 700;
  localparam int HoldCycles    = 3000;

  typedef struct packed {
    logic signed [31:0] stat;
    logic [31:0]        df;
    logic               inv;
  } bm_result_t;

  typedef enum logic {RowCfg, RowReq} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [8:0]         cfg_value;
    logic               act;
    logic [7:0]         idx;
    logic signed [31:0] score;
    logic               les;
    bit                 typed;
    bm_result_t         want;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bmr_req_if req ();
  bmr_res_if res ();
  bmr_cfg_if cfg ();

  brunner_munzel_rank_test_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  // shadow copy of the block's stores and register
  logic signed [31:0] score_mem  [MaxSubjects];
  logic               lesion_mem [MaxSubjects];
  int                 grank_mem  [MaxSubjects];
  logic [8:0]         count_reg;

  bm_result_t  stats_q [$];
  stim_row_t   dir_tab [$];
  int          err_cnt = 0;
  int          idle_cnt = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  function automatic int subj_in_use();
    int v;
    v = count_reg;
    if (v < 2) v = 2;
    if (v > MaxSubjects) v = MaxSubjects;
    return v;
  endfunction

  // doubled midrank of subject i among subjects below n; grp < 0 means everyone
  function automatic int midrank2(int i, int n, int grp);
    int less;
    int eq;
    less = 0;
    eq   = 0;
    for (int j = 0; j < n; j++) begin
      if (grp >= 0 && int'(lesion_mem[j]) != grp) continue;
      if (score_mem[j] < score_mem[i]) less++;
      else if (score_mem[j] == score_mem[i]) eq++;
    end
    return 2 * less + eq + 1;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res_v;
    logic [63:0] cand;
    res_v = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = res_v | (64'd1 << b);
      if (cand * cand <= v) res_v = cand;
    end
    return res_v;
  endfunction

  // apply one request to the shadow state; returns 1 when a column closes
  function automatic bit bm_apply(logic act, logic [7:0] idx, logic signed [31:0] sc,
                                  logic les, output bm_result_t r);
    int          n;
    int          g;
    longint      sum [2];
    longint      sd  [2];
    longint      sq  [2];
    longint      cnt [2];
    longint      d;
    longint      t;
    logic [63:0] g0, g1, p, q1, x, y, w, k, at, mag, neg;
    logic [191:0] num, den, quo;
    r = '0;
    if (act == ActScore) begin
      score_mem[idx] = sc;
      return 1'b0;
    end
    n = subj_in_use();
    if (int'(idx) >= n) return 1'b0;
    lesion_mem[idx] = les;
    grank_mem[idx]  = midrank2(idx, n, -1);
    if (int'(idx) != n - 1) return 1'b0;
    for (int gi = 0; gi < 2; gi++) begin
      sum[gi] = 0; sd[gi] = 0; sq[gi] = 0; cnt[gi] = 0;
    end
    for (int i = 0; i < n; i++) begin
      g = lesion_mem[i];
      d = longint'(grank_mem[i]) - longint'(midrank2(i, n, g));
      sum[g] += grank_mem[i];
      sd[g]  += d;
      sq[g]  += d * d;
      cnt[g] += 1;
    end
    r.inv = 1'b1;
    if (cnt[0] < 2 || cnt[1] < 2) return 1'b1;
    g0 = cnt[0] * sq[0] - sd[0] * sd[0];
    g1 = cnt[1] * sq[1] - sd[1] * sd[1];
    p  = cnt[0] - 1;
    q1 = cnt[1] - 1;
    x  = g0 * q1;
    y  = g1 * p;
    w  = x + y;
    if (w == 0) return 1'b1;
    k  = p * q1;
    t  = sum[0] * cnt[1] - sum[1] * cnt[0];
    at = (t < 0) ? 64'(-t) : 64'(t);

    num = 192'(at) * 192'(at) * 192'(k);
    num = num << 32;
    den = 192'(w) * 192'(n) * 192'(n);
    quo = num / den;
    mag = (quo >= (192'd1 << 62)) ? 64'h8000_0000 : isqrt64(quo[63:0]);
    if (t >= 0) begin
      r.stat = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      neg    = 64'd0 - mag;
      r.stat = neg[31:0];
    end

    num = 192'(w) * 192'(w) * 192'(p) * 192'(q1) * 192'(65536);
    den = 192'(x) * 192'(x) * 192'(q1) + 192'(y) * 192'(y) * 192'(p);
    quo = num / den;
    r.df  = (quo > 192'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    r.inv = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] pick_score();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3, 4: return $signed($urandom_range(0, 4)) - 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t mk_row(row_kind_e kind, logic [8:0] cv, logic act,
                                       logic [7:0] idx, logic signed [31:0] sc, logic les,
                                       bit typed, bm_result_t want);
    stim_row_t row;
    row.kind = kind; row.cfg_value = cv; row.act = act; row.idx = idx;
    row.score = sc; row.les = les; row.typed = typed; row.want = want;
    return row;
  endfunction

  // offer one request, predict it once it is accepted
  task automatic send_item(logic act, logic [7:0] idx, logic signed [31:0] sc, logic les,
                           bit typed, bm_result_t want);
    bm_result_t pr;
    bit         has;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    req.valid         <= 1'b1;
    req.action        <= act;
    req.subject_index <= idx;
    req.score         <= sc;
    req.lesioned      <= les;
    do @(posedge clk_i); while (!req.ready);
    has = bm_apply(act, idx, sc, les, pr);
    if (has) stats_q.push_back(typed ? want : pr);
    @(negedge clk_i);
  endtask

  // write the count register once the block has drained
  task automatic write_count(logic [8:0] v);
    req.valid <= 1'b0;
    while (stats_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg.valid         <= 1'b1;
    cfg.subject_count <= v;
    do @(posedge clk_i); while (!cfg.ready);
    count_reg = v;
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // one well-formed column with random content and the odd stray request
  task automatic run_column(int n);
    int          mode;
    logic        les;
    bm_result_t  none;
    none = '0;
    mode = $urandom_range(0, 5);
    if (n <= 32) begin
      repeat ($urandom_range(0, n))
        send_item(ActScore, 8'($urandom_range(0, n - 1)), pick_score(), 1'($urandom),
                  1'b0, none);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: send_item(ActScore, 8'($urandom), pick_score(), 1'($urandom), 1'b0, none);
          1: if (n < MaxSubjects)
               send_item(ActMember, 8'($urandom_range(n, 255)), $urandom, 1'($urandom),
                         1'b0, none);
          default: if (i > 0)
               send_item(ActMember, 8'($urandom_range(0, i - 1)), $urandom, 1'($urandom),
                         1'b0, none);
        endcase
      end
      case (mode)
        3:       les = 1'b0;
        4:       les = 1'b1;
        5:       les = (i == 0);
        default: les = 1'($urandom);
      endcase
      send_item(ActMember, 8'(i), $urandom, les, 1'b0, none);
    end
  endtask

  task automatic run_phase(logic [8:0] cv, int cols);
    write_count(cv);
    repeat (cols) run_column(subj_in_use());
  endtask

  // result checker: oldest expectation first
  always @(posedge clk_i) begin
    bm_result_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (stats_q.size() == 0) begin
        $display("%0t: unexpected result stat=%h df=%h invalid=%b", $time,
                 res.statistic, res.degrees_freedom, res.invalid);
        err_cnt++;
      end else begin
        e = stats_q.pop_front();
        if (res.statistic !== e.stat) begin
          $display("%0t: statistic expected %h actual %h", $time, e.stat, res.statistic);
          err_cnt++;
        end
        if (res.degrees_freedom !== e.df) begin
          $display("%0t: degrees_freedom expected %h actual %h", $time, e.df,
                   res.degrees_freedom);
          err_cnt++;
        end
        if (res.invalid !== e.inv) begin
          $display("%0t: invalid expected %b actual %b", $time, e.inv, res.invalid);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result sink: random stall bursts, one long hold-off on request
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  initial begin
    bm_result_t none;
    bm_result_t bad_col;
    none    = '0;
    bad_col = '{stat: 32'sd0, df: 32'd0, inv: 1'b1};
    req.valid = 1'b0; req.action = ActScore; req.subject_index = '0;
    req.score = '0;   req.lesioned = 1'b0;
    cfg.valid = 1'b0; cfg.subject_count = 9'd256;
    for (int i = 0; i < MaxSubjects; i++) begin
      score_mem[i] = '0; lesion_mem[i] = 1'b0; grank_mem[i] = 0;
    end
    count_reg = 9'd256;

    // zero count clamps to two: one subject per group, so the column is invalid
    dir_tab.push_back(mk_row(RowCfg, 9'd0, ActScore, 8'd0, 0, 1'b0, 1'b0, none));
    dir_tab.push_back(mk_row(RowReq, 9'd0, ActScore, 8'd0, 32'sh8000_0000, 1'b1, 1'b0, none));
    dir_tab.push_back(mk_row(RowReq, 9'd0, ActScore, 8'd1, 32'sh7FFF_FFFF, 1'b0, 1'b0, none));
    dir_tab.push_back(mk_row(RowReq, 9'd0, ActMember, 8'd0, 0, 1'b0, 1'b0, none));
    dir_tab.push_back(mk_row(RowReq, 9'd0, ActMember, 8'd1, 0, 1'b1, 1'b1, bad_col));
    // subject beyond the count: dropped
    dir_tab.push_back(mk_row(RowReq, 9'd0, ActMember, 8'd5, -1, 1'b1, 1'b0, none));
    dir_tab.push_back(mk_row(RowReq, 9'd0, ActScore, 8'd255, -1, 1'b1, 1'b0, none));
    // four subjects, two of them at the score extremes
    dir_tab.push_back(mk_row(RowCfg, 9'd4, ActScore, 8'd0, 0, 1'b0, 1'b0, none));
    dir_tab.push_back(mk_row(RowReq, 9'd0, ActScore, 8'd2, 32'sd0, 1'b0, 1'b0, none));
    dir_tab.push_back(mk_row(RowReq, 9'd0, ActScore, 8'd3, -32'sd1, 1'b0, 1'b0, none));
    for (int i = 0; i < 4; i++)
      dir_tab.push_back(mk_row(RowReq, 9'd0, ActMember, 8'(i), 0, 1'(i), 1'b0, none));
    // all scores tied: zero variance, invalid column
    for (int i = 0; i < 4; i++)
      dir_tab.push_back(mk_row(RowReq, 9'd0, ActScore, 8'(i), 32'sd7, 1'b0, 1'b0, none));
    for (int i = 0; i < 4; i++)
      dir_tab.push_back(mk_row(RowReq, 9'd0, ActMember, 8'(i), 0, 1'(i), i == 3, bad_col));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == RowCfg) write_count(dir_tab[r].cfg_value);
      else send_item(dir_tab[r].act, dir_tab[r].idx, dir_tab[r].score, dir_tab[r].les,
                     dir_tab[r].typed, dir_tab[r].want);
    end

    // fill every score so that no rank ever reads an unwritten entry
    for (int i = 0; i < MaxSubjects; i++)
      send_item(ActScore, 8'(i), pick_score(), 1'($urandom), 1'b0, none);

    run_phase(9'd3, 15);
    run_phase(9'd5, 8);
    run_phase(9'd1, 10);
    run_phase(9'd4, 10);
    run_phase(9'd7, 5);
    run_phase(9'd12, 3);
    // short columns against a stalled sink so the block backs up
    write_count(9'd2);
    hold_req = 1'b1;
    repeat (20) run_column(2);
    run_phase(9'd9, 4);
    run_phase(9'd511, 1);
    run_phase(9'd16, 2);
    run_phase(9'd6, 5);
    quiet = 1'b1;
    run_phase(9'd3, 8);

    req.valid <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0 && stats_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bmr_pkg.sv
src/bmr_if.sv
src/bmr_mul.sv
src/bmr_div.sv
src/brunner_munzel_rank_test_core.sv
verif/tb.sv
